[rtl/utf8d_pkg.sv]
// Package: shared widths, constants, decode result type and lead-length helper.
`timescale 1ns / 1ps
`default_nettype none
package utf8d_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;
    localparam int USED_W = 3;
    localparam int WIN_N  = 4;

    localparam logic [CP_W-1:0] REPL_CP    = 21'h00FFFD;
    localparam logic [CP_W-1:0] MIN_CP3    = 21'h000800;
    localparam logic [CP_W-1:0] SURR_LO    = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI    = 21'h00DFFF;
    localparam logic [CP_W-1:0] MIN_CP4    = 21'h010000;
    localparam logic [CP_W-1:0] MAX_CP     = 21'h10FFFF;
    localparam logic [CP_W-1:0] MIN_CP2    = 21'h000080;

    // Result of one decode attempt at the head of the byte window.
    typedef struct packed {
        logic [USED_W-1:0] need;
        logic              ok;
        logic [CP_W-1:0]   cp;
    } seq_res_t;

    // Sequence length selected by a lead byte; invalid leads count as one.
    function automatic logic [USED_W-1:0] seq_len(input logic [BYTE_W-1:0] lead);
        logic [USED_W-1:0] len;
        len = 3'd1;
        if (lead[7] == 1'b0)
            len = 3'd1;
        else if (lead[7:5] == 3'b110)
            len = 3'd2;
        else if (lead[7:4] == 4'b1110)
            len = 3'd3;
        else if (lead[7:3] == 5'b11110)
            len = 3'd4;
        return len;
    endfunction

endpackage
`default_nettype wire

[rtl/utf8d_byte_if.sv]
// Interface: source byte channel (valid/ready with byte and end flag).
`timescale 1ns / 1ps
`default_nettype none
interface utf8d_byte_if
    import utf8d_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_input;

    modport source (output valid, output data_byte, output end_of_input, input ready);
    modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface
`default_nettype wire

[rtl/utf8d_cp_if.sv]
// Interface: decoded code point channel (valid/ready with result fields).
`timescale 1ns / 1ps
`default_nettype none
interface utf8d_cp_if
    import utf8d_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CP_W-1:0]   code_point;
    logic [USED_W-1:0] bytes_used;
    logic              is_replacement;
    logic              last_of_run;

    modport source (output valid, output code_point, output bytes_used,
                    output is_replacement, output last_of_run, input ready);
    modport sink   (input valid, input code_point, input bytes_used,
                    input is_replacement, input last_of_run, output ready);
endinterface
`default_nettype wire

[rtl/utf8d_seq_decode.sv]
// Shared decode unit: validates and assembles the sequence at the window head.
`timescale 1ns / 1ps
`default_nettype none
module utf8d_seq_decode
    import utf8d_pkg::*;
(
    input  wire logic [WIN_N-1:0][BYTE_W-1:0] win,
    output seq_res_t                          res
);
    logic [USED_W-1:0] len;
    logic              c1, c2, c3;
    logic [CP_W-1:0]   v2, v3, v4;

    always_comb
    begin
        len = seq_len(win[0]);
        c1  = (win[1][7:6] == 2'b10);
        c2  = (win[2][7:6] == 2'b10);
        c3  = (win[3][7:6] == 2'b10);
        v2  = {10'd0, win[0][4:0], win[1][5:0]};
        v3  = {5'd0, win[0][3:0], win[1][5:0], win[2][5:0]};
        v4  = {win[0][2:0], win[1][5:0], win[2][5:0], win[3][5:0]};

        res.need = len;
        res.ok   = 1'b0;
        res.cp   = REPL_CP;
        case (len)
            3'd1:
            begin
                res.ok = (win[0][7] == 1'b0);
                res.cp = {13'd0, win[0]};
            end
            3'd2:
            begin
                res.ok = c1 && (v2 >= MIN_CP2);
                res.cp = v2;
            end
            3'd3:
            begin
                res.ok = c1 && c2 && (v3 >= MIN_CP3) && !((v3 >= SURR_LO) && (v3 <= SURR_HI));
                res.cp = v3;
            end
            3'd4:
            begin
                res.ok = c1 && c2 && c3 && (v4 >= MIN_CP4) && (v4 <= MAX_CP);
                res.cp = v4;
            end
            default:
            begin
                res.ok = 1'b0;
                res.cp = REPL_CP;
            end
        endcase
    end
endmodule
`default_nettype wire

[rtl/utf8_stream_decoder_unit.sv]
// Top level: validating UTF-8 stream decoder with byte window and sequencer.
// Flow: an accepted byte is registered into the window; in DEC each result
//   is then registered on the output. A new byte is taken only in IDLE.
// Throughput: the single shared decode unit handles one sequence per cycle
//   while the output is free; no byte is taken until a transfer's last result is registered.
// Reset (rst_n low, async): window empty, sequencer idle, output not valid.
`timescale 1ns / 1ps
`default_nettype none
module utf8_stream_decoder_unit
    import utf8d_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    utf8d_byte_if.sink    byte_ch,
    utf8d_cp_if.source    cp_ch
);
    // One-hot sequencer: IDLE takes a byte, DEC emits one result per cycle while the output is free.
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DEC  = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // Byte window, left aligned: entry 0 is always the current lead.
    logic [WIN_N-1:0][BYTE_W-1:0] win_reg, win_next;
    logic [USED_W-1:0]            cnt_reg, cnt_next;
    logic                         eoi_reg, eoi_next;

    // Output register
    logic              ov_reg, ov_next;
    logic [CP_W-1:0]   ocp_reg, ocp_next;
    logic [USED_W-1:0] oused_reg, oused_next;
    logic              orepl_reg, orepl_next;
    logic              olast_reg, olast_next;

    seq_res_t          res;
    logic              accept;
    logic              out_free;
    logic              waiting;
    logic              good;
    logic [USED_W-1:0] used;
    logic [USED_W-1:0] cnt_after;
    logic [BYTE_W-1:0] next_lead;
    logic              last;
    logic              emit;
    logic [USED_W-1:0] src_idx;

    utf8d_seq_decode u_dec (
        .win (win_reg),
        .res (res)
    );

    assign byte_ch.ready     = (state_reg == ST_IDLE);
    assign accept            = byte_ch.valid && byte_ch.ready;

    assign cp_ch.valid          = ov_reg;
    assign cp_ch.code_point     = ocp_reg;
    assign cp_ch.bytes_used     = oused_reg;
    assign cp_ch.is_replacement = orepl_reg;
    assign cp_ch.last_of_run    = olast_reg;

    assign out_free = !ov_reg || cp_ch.ready;

    always_comb
    begin
        // incomplete sequence with more bytes still to come: hold it
        waiting   = (cnt_reg < res.need) && !eoi_reg;
        // truncated at end of input counts as a bad sequence
        good      = res.ok && (cnt_reg >= res.need);
        used      = good ? res.need : 3'd1;
        cnt_after = cnt_reg - used;

        case (used)
            3'd1:    next_lead = win_reg[1];
            3'd2:    next_lead = win_reg[2];
            3'd3:    next_lead = win_reg[3];
            default: next_lead = win_reg[0];
        endcase

        // final result of this transfer if nothing more will decode after it
        last = (cnt_after == 3'd0) || (!eoi_reg && (cnt_after < seq_len(next_lead)));
        emit = (state_reg == ST_DEC) && (cnt_reg != 3'd0) && !waiting && out_free;

        state_next = state_reg;
        win_next   = win_reg;
        cnt_next   = cnt_reg;
        eoi_next   = eoi_reg;

        ov_next    = ov_reg;
        ocp_next   = ocp_reg;
        oused_next = oused_reg;
        orepl_next = orepl_reg;
        olast_next = olast_reg;
        src_idx    = 3'd0;

        if (ov_reg && cp_ch.ready)
            ov_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    win_next[cnt_reg[1:0]] = byte_ch.data_byte;
                    cnt_next   = cnt_reg + 3'd1;
                    eoi_next   = byte_ch.end_of_input;
                    state_next = ST_DEC;
                end
            end
            ST_DEC:
            begin
                if ((cnt_reg == 3'd0) || waiting)
                begin
                    state_next = ST_IDLE;
                end
                else if (emit)
                begin
                    ov_next    = 1'b1;
                    ocp_next   = good ? res.cp : REPL_CP;
                    oused_next = used;
                    orepl_next = !good;
                    olast_next = last;
                    // drop the consumed bytes off the window head
                    for (int i = 0; i < WIN_N; i++)
                    begin
                        src_idx = 3'(i) + used;
                        if (src_idx < 3'(WIN_N))
                            win_next[i] = win_reg[src_idx[1:0]];
                    end
                    cnt_next = cnt_after;
                    if (last)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            eoi_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            eoi_reg   <= eoi_next;
            ov_reg    <= ov_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        win_reg   <= win_next;
        ocp_reg   <= ocp_next;
        oused_reg <= oused_next;
        orepl_reg <= orepl_next;
        olast_reg <= olast_next;
    end
endmodule
`default_nettype wire

[tb/utf8_stream_decoder_unit_tb.sv]
// Self-checking testbench for the UTF-8 stream decoder: directed and random byte streams.
`timescale 1ns / 1ps
module utf8_stream_decoder_unit_tb;
    import utf8d_pkg::*;

    // One expected or observed decoder result, field order as on the cp channel.
    typedef struct packed {
        logic [CP_W-1:0]   cp;
        logic [USED_W-1:0] used;
        logic              repl;
        logic              last;
    } cp_item_t;

    // Scoreboard: keeps its own copy of the partial-sequence buffer, predicts
    // the code points each accepted byte releases, and checks them in order.
    class code_point_scoreboard;
        logic [BYTE_W-1:0] held [3];
        int unsigned       held_cnt;
        cp_item_t          due_cps [$];
        int unsigned       mismatches;

        function new();
            held_cnt   = 0;
            mismatches = 0;
        endfunction

        // Bytes called for by a lead; stray continuations and F8-FF count as one.
        function int unsigned lead_span(logic [7:0] b);
            casez (b)
                8'b0???????: return 1;
                8'b110?????: return 2;
                8'b1110????: return 3;
                8'b11110???: return 4;
                default:     return 1;
            endcase
        endfunction

        // w holds the sequence with its lead in the low byte.
        function bit try_scalar(logic [31:0] w, int unsigned len,
                                output logic [CP_W-1:0] v);
            bit          tails_ok;
            int unsigned k;
            tails_ok = 1'b1;
            for (k = 1; k < len; k++)
                if (w[8*k+6 +: 2] != 2'b10)
                    tails_ok = 1'b0;
            case (len)
                1:
                begin
                    v = {14'd0, w[6:0]};
                    return !w[7];
                end
                2:
                begin
                    v = {10'd0, w[4:0], w[13:8]};
                    return tails_ok && v >= MIN_CP2;
                end
                3:
                begin
                    v = {5'd0, w[3:0], w[13:8], w[21:16]};
                    return tails_ok && v >= MIN_CP3 && !(v >= SURR_LO && v <= SURR_HI);
                end
                default:
                begin
                    v = {w[2:0], w[13:8], w[21:16], w[29:24]};
                    return tails_ok && v >= MIN_CP4 && v <= MAX_CP;
                end
            endcase
        endfunction

        // Accepted byte: decode from the head of the window until it runs dry.
        function void take_byte(logic [7:0] b, logic eoi);
            logic [31:0]     win;
            int unsigned     n;
            int unsigned     pos;
            int unsigned     need;
            int unsigned     cnt;
            int unsigned     k;
            logic [CP_W-1:0] v;
            cp_item_t        run [4];
            win = '0;
            for (k = 0; k < held_cnt; k++)
                win[8*k +: 8] = held[k];
            win[8*held_cnt +: 8] = b;
            n   = held_cnt + 1;
            pos = 0;
            cnt = 0;
            while (pos < n)
            begin
                need = lead_span(win[8*pos +: 8]);
                if (n - pos < need)
                begin
                    if (!eoi)
                        break;
                    // cut off by end of input: reject the lead, rescan the rest
                    run[cnt] = {REPL_CP, 3'd1, 1'b1, 1'b0};
                    pos++;
                end
                else if (try_scalar(win >> (8*pos), need, v))
                begin
                    run[cnt] = {v, USED_W'(need), 1'b0, 1'b0};
                    pos += need;
                end
                else
                begin
                    run[cnt] = {REPL_CP, 3'd1, 1'b1, 1'b0};
                    pos++;
                end
                cnt++;
            end
            if (cnt > 0)
                run[cnt-1].last = 1'b1;
            for (k = 0; k < cnt; k++)
                due_cps = {due_cps, run[k]};
            held_cnt = 0;
            if (!eoi)
            begin
                for (k = 0; pos + k < n; k++)
                    held[k] = win[8*(pos+k) +: 8];
                held_cnt = n - pos;
            end
        endfunction

        function void flag(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                mismatches++;
                $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
            end
        endfunction

        function void match_code_point(cp_item_t got);
            cp_item_t want;
            if (due_cps.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, got cp=0x%0h used=%0d",
                         $time, got.cp, got.used);
                return;
            end
            want = due_cps.pop_front();
            flag("code_point", 32'(want.cp), 32'(got.cp));
            flag("bytes_used", 32'(want.used), 32'(got.used));
            flag("is_replacement", 32'(want.repl), 32'(got.repl));
            flag("last_of_run", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    utf8d_byte_if byte_ch ();
    utf8d_cp_if   cp_ch ();

    utf8_stream_decoder_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_ch (byte_ch),
        .cp_ch   (cp_ch)
    );

    code_point_scoreboard sb;

    // Per-cycle idle odds in percent; set per phase by the main sequence.
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    // Long receiver hold-off, counted down by the receiver process.
    int          hold_left      = 0;
    int unsigned items_sent     = 0;

    always #4 clk = ~clk;

    // Receiver: ready changes at the falling edge, results sampled at the rising edge.
    initial
    begin
        cp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                cp_ch.ready <= 1'b0;
            end
            else
                cp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && cp_ch.valid && cp_ch.ready)
            sb.match_code_point({cp_ch.code_point, cp_ch.bytes_used,
                                 cp_ch.is_replacement, cp_ch.last_of_run});
    end

    // Present one byte after random idle cycles; return once the transfer happened.
    task automatic send_byte(input logic [7:0] b, input logic eoi);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            byte_ch.valid <= 1'b0;
            @(negedge clk);
        end
        byte_ch.valid        <= 1'b1;
        byte_ch.data_byte    <= b;
        byte_ch.end_of_input <= eoi;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        sb.take_byte(b, eoi);
        items_sent++;
    endtask

    // Stop offering bytes and wait until every predicted code point came out.
    task automatic drain_results();
        @(negedge clk);
        byte_ch.valid <= 1'b0;
        while (sb.due_cps.size() != 0)
            @(posedge clk);
    endtask

    // Encodes v in len bytes, lead in the low byte; also builds overlong and
    // out-of-range forms since nothing is checked here.
    function automatic logic [31:0] utf8_bytes(logic [CP_W-1:0] v, int unsigned len);
        case (len)
            1:       return {24'd0, 1'b0, v[6:0]};
            2:       return {16'd0, 2'b10, v[5:0], 3'b110, v[10:6]};
            3:       return {8'd0, 2'b10, v[5:0], 2'b10, v[11:6], 4'b1110, v[15:12]};
            default: return {2'b10, v[5:0], 2'b10, v[11:6], 2'b10, v[17:12],
                             5'b11110, v[20:18]};
        endcase
    endfunction

    // One random sequence: mostly well-formed characters, then overlong,
    // surrogate, above-range, damaged or truncated ones, and plain noise.
    // End-of-input lands at random, also inside a sequence.
    task automatic send_unit();
        logic [31:0]     seq;
        logic [CP_W-1:0] v;
        int unsigned     kind;
        int unsigned     len;
        int unsigned     k;
        kind = $urandom_range(99);
        len  = $urandom_range(4, 1);
        v    = '0;
        if (kind < 58 || (kind >= 76 && kind < 88))
        begin
            case (len)
                1:       v = CP_W'($urandom_range(8'h7F, 0));
                2:       v = CP_W'($urandom_range(11'h7FF, 8'h80));
                3:
                begin
                    v = CP_W'($urandom_range(16'hFFFF, 12'h800));
                    if (v >= SURR_LO && v <= SURR_HI)
                        v = v - 21'h800;
                end
                default: v = CP_W'($urandom_range(MAX_CP, MIN_CP4));
            endcase
        end
        else if (kind < 66)
        begin
            len = $urandom_range(4, 2);
            v   = CP_W'((len == 2) ? $urandom_range(MIN_CP2 - 1, 0) :
                        (len == 3) ? $urandom_range(MIN_CP3 - 1, 0) :
                                     $urandom_range(MIN_CP4 - 1, 0));
        end
        else if (kind < 71)
        begin
            len = 3;
            v   = CP_W'($urandom_range(SURR_HI, SURR_LO));
        end
        else if (kind < 76)
        begin
            len = 4;
            v   = CP_W'($urandom_range(21'h1FFFFF, MAX_CP + 1));
        end
        seq = utf8_bytes(v, len);
        if (kind >= 76 && kind < 88)
        begin
            if ($urandom_range(1) == 1 && len > 1)
                len = $urandom_range(len - 1, 1);
            else
            begin
                k = (len > 1) ? $urandom_range(len - 1, 1) : 0;
                seq[8*k +: 8] = 8'($urandom_range(255, 0));
            end
        end
        else if (kind >= 88)
        begin
            len = $urandom_range(3, 1);
            seq = $urandom;
        end
        for (k = 0; k < len; k++)
            send_byte(seq[8*k +: 8], $urandom_range(99) < 5);
    endtask

    // Main sequence: reset, directed bytes, then four idling phases with a
    // receiver hold-off between the first two.
    initial
    begin
        logic [8:0] directed [25];
        int         send_pcts [4];
        int         recv_pcts [4];
        int         p;
        int         i;
        sb = new();
        rst_n                = 1'b0;
        byte_ch.valid        = 1'b0;
        byte_ch.data_byte    = '0;
        byte_ch.end_of_input = 1'b0;
        send_pcts = '{0, 85, 0, 31};
        recv_pcts = '{0, 0, 85, 31};
        // bit 8 is end-of-input: NUL with flush, DEL, U+07FF, overlong C0 80,
        // surrogate ED A0 80, F4 90 80 80 above U+10FFFF, U+10FFFF, stray 80,
        // FF, bad continuation C2 41, F4 8F BF cut off by end of input, F8
        directed = '{9'h100, 9'h07F, 9'h0DF, 9'h0BF, 9'h0C0, 9'h080, 9'h0ED,
                     9'h0A0, 9'h080, 9'h0F4, 9'h090, 9'h080, 9'h080, 9'h0F4,
                     9'h08F, 9'h0BF, 9'h0BF, 9'h080, 9'h0FF, 9'h0C2, 9'h041,
                     9'h0F4, 9'h08F, 9'h1BF, 9'h0F8};
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < 25; i++)
            send_byte(directed[i][7:0], directed[i][8]);
        drain_results();

        for (p = 0; p < 4; p++)
        begin
            send_idle_pct  = send_pcts[p];
            recv_stall_pct = recv_pcts[p];
            while (items_sent < 25 + 120 * (p + 1))
                send_unit();
            drain_results();
            if (p == 0)
            begin
                // receiver goes dark while bytes keep coming: input must back up
                hold_left = 250;
                for (i = 0; i < 12; i++)
                    send_unit();
                drain_results();
            end
        end

        // flush whatever is still buffered, then allow for stragglers
        send_byte(8'h41, 1'b1);
        drain_results();
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0 && sb.due_cps.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("%0t: timeout, %0d results still expected", $time, sb.due_cps.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
